FILE: hdl/ecrtc_pkg.sv
// Shared types and constants for the EGA CRT controller timing generator.
`timescale 1ns / 1ps

package ecrtc_pkg;

	localparam int unsigned MAX_REG_INDEX_DEF = 24;
	localparam logic [3:0]  CHAR_WIDTH_RST    = 4'd8;

	localparam logic [4:0] IDX_INVALID    = 5'd25;
	localparam logic [4:0] IDX_H_TOTAL    = 5'd0;
	localparam logic [4:0] IDX_H_DISP_END = 5'd1;
	localparam logic [4:0] IDX_H_BLK_ST   = 5'd2;
	localparam logic [4:0] IDX_H_BLK_END  = 5'd3;
	localparam logic [4:0] IDX_H_SYNC_ST  = 5'd4;
	localparam logic [4:0] IDX_H_SYNC_END = 5'd5;
	localparam logic [4:0] IDX_V_TOTAL    = 5'd6;
	localparam logic [4:0] IDX_OVERFLOW   = 5'd7;
	localparam logic [4:0] IDX_ROW_SCAN   = 5'd8;
	localparam logic [4:0] IDX_MAX_SCAN   = 5'd9;
	localparam logic [4:0] IDX_START_HI   = 5'd12;
	localparam logic [4:0] IDX_START_LO   = 5'd13;
	localparam logic [4:0] IDX_CURSOR_HI  = 5'd14;
	localparam logic [4:0] IDX_CURSOR_LO  = 5'd15;
	localparam logic [4:0] IDX_V_SYNC_ST  = 5'd16;
	localparam logic [4:0] IDX_V_SYNC_END = 5'd17;
	localparam logic [4:0] IDX_V_DISP_END = 5'd18;
	localparam logic [4:0] IDX_OFFSET     = 5'd19;
	localparam logic [4:0] IDX_V_BLK_ST   = 5'd21;
	localparam logic [4:0] IDX_V_BLK_END  = 5'd22;
	localparam logic [4:0] IDX_MODE_CTRL  = 5'd23;
	localparam logic [4:0] IDX_LINE_CMP   = 5'd24;

	localparam logic [7:0] RD_NO_REG = 8'hFF;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SELECT = 2'd1,
		OP_WRITE  = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	// Timing register contents handed from the register file to the counters.
	typedef struct packed {
		logic [7:0]  htotal;
		logic [7:0]  hsync;
		logic [8:0]  vtotal;
		logic [8:0]  vsync;
		logic [4:0]  max_scan;
		logic [15:0] start_addr;
		logic [7:0]  offset;
		logic        byte_mode;
	} regs_t;

endpackage

FILE: hdl/ecrtc_regfile.sv
// Indexed register file: index select, data write, cursor read, dirty flag.
`timescale 1ns / 1ps

module ecrtc_regfile #(
	parameter int unsigned MAX_REG_INDEX = ecrtc_pkg::MAX_REG_INDEX_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sel_en,
	input  logic                wr_en,
	input  logic [7:0]          value,
	input  logic                clear_dirty,
	output ecrtc_pkg::regs_t    regs,
	output logic                dirty,
	output logic [7:0]          rdata
);

	logic [4:0]        sel_q;
	logic [15:0]       cursor_q;
	logic              dirty_q;
	ecrtc_pkg::regs_t  regs_q;
	logic [4:0]        idx;
	logic              dirty_only;

	assign idx = value[4:0];

	always_comb begin
		dirty_only = sel_q inside {ecrtc_pkg::IDX_H_DISP_END, ecrtc_pkg::IDX_H_BLK_ST,
			ecrtc_pkg::IDX_H_BLK_END, ecrtc_pkg::IDX_H_SYNC_END, ecrtc_pkg::IDX_ROW_SCAN,
			ecrtc_pkg::IDX_V_SYNC_END, ecrtc_pkg::IDX_V_DISP_END, ecrtc_pkg::IDX_V_BLK_ST,
			ecrtc_pkg::IDX_V_BLK_END, ecrtc_pkg::IDX_LINE_CMP};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q    <= ecrtc_pkg::IDX_INVALID;
			cursor_q <= '0;
			dirty_q  <= 1'b1;
			regs_q   <= '0;
		end else begin
			if (clear_dirty) begin
				dirty_q <= 1'b0;
			end
			if (sel_en) begin
				sel_q <= (idx > 5'(MAX_REG_INDEX)) ? ecrtc_pkg::IDX_INVALID : idx;
			end
			if (wr_en) begin
				case (sel_q)
					ecrtc_pkg::IDX_H_TOTAL: begin
						regs_q.htotal <= value;
						dirty_q       <= 1'b1;
					end
					ecrtc_pkg::IDX_H_SYNC_ST: begin
						regs_q.hsync <= value;
						dirty_q      <= 1'b1;
					end
					ecrtc_pkg::IDX_V_TOTAL: begin
						regs_q.vtotal[7:0] <= value;
						dirty_q            <= 1'b1;
					end
					ecrtc_pkg::IDX_OVERFLOW: begin
						regs_q.vtotal[8] <= value[0];
						regs_q.vsync[8]  <= value[2];
						dirty_q          <= 1'b1;
					end
					ecrtc_pkg::IDX_MAX_SCAN: begin
						regs_q.max_scan <= value[4:0];
						dirty_q         <= 1'b1;
					end
					ecrtc_pkg::IDX_START_HI: regs_q.start_addr[15:8] <= value;
					ecrtc_pkg::IDX_START_LO: regs_q.start_addr[7:0]  <= value;
					ecrtc_pkg::IDX_CURSOR_HI: cursor_q[15:8] <= value;
					ecrtc_pkg::IDX_CURSOR_LO: cursor_q[7:0]  <= value;
					ecrtc_pkg::IDX_V_SYNC_ST: begin
						regs_q.vsync[7:0] <= value;
						dirty_q           <= 1'b1;
					end
					ecrtc_pkg::IDX_OFFSET: begin
						regs_q.offset <= value;
						dirty_q       <= 1'b1;
					end
					ecrtc_pkg::IDX_MODE_CTRL: begin
						regs_q.byte_mode <= value[6];
						dirty_q          <= 1'b1;
					end
					default: begin
						if (dirty_only) begin
							dirty_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_comb begin
		case (sel_q)
			ecrtc_pkg::IDX_CURSOR_HI: rdata = cursor_q[15:8];
			ecrtc_pkg::IDX_CURSOR_LO: rdata = cursor_q[7:0];
			default:                  rdata = ecrtc_pkg::RD_NO_REG;
		endcase
	end

	assign regs  = regs_q;
	assign dirty = dirty_q;

endmodule

FILE: hdl/ega_crtc_timing_generator.sv
// Top level of the EGA CRT controller timing generator.
`timescale 1ns / 1ps
// An accepted word passes the input register and then the result register to become its result word.
// Throughput: one word per clock while the output is not stalled; the whole tick update (pixel add, line compare,
// row-address multiply-add) resolves between the input register and the state registers.
// Reset: all counters and derived timing clear, char width returns to 8, the selected
// index is invalid and the configuration counts as changed; no words are in flight.
// Config writes are always ready; the new char width and the derived timing are registered at the write.

module ega_crtc_timing_generator #(
	parameter int unsigned MAX_REG_INDEX = ecrtc_pkg::MAX_REG_INDEX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  char_width,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  value,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        end_of_row,
	output logic        new_frame,
	output logic        render_frame,
	output logic        mode_changed,
	output logic [15:0] memory_address,
	output logic [4:0]  scan_row,
	output logic        blink_fast,
	output logic        blink_slow
);

	// Input register stage
	logic               valid_s1;
	ecrtc_pkg::op_t     op_s1;
	logic [7:0]         value_s1;

	// Handshake
	logic advance;
	logic in_fire;
	logic step_fire;
	logic cfg_fire;

	// Configuration and derived timing
	logic [3:0]  cw_q;
	logic [11:0] line_len_q;
	logic [11:0] hsync_px_q;
	logic [8:0]  frame_lines_q;
	logic [8:0]  vsync_line_q;
	logic [8:0]  row_stride_q;

	// Counters
	logic [11:0] pixel_q;
	logic [8:0]  line_q;
	logic [8:0]  char_row_q;
	logic [4:0]  scan_q;
	logic [15:0] mem_addr_q;
	logic [4:0]  frame_cnt_q;
	logic        blink16_q;
	logic        blink32_q;

	// Result register
	logic        out_valid_q;
	logic [7:0]  rd_q;
	logic        eor_q;
	logic        nf_q;
	logic        rf_q;
	logic        mc_q;

	// Register file hookup
	ecrtc_pkg::regs_t regs;
	logic             dirty;
	logic [7:0]       rf_rdata;
	logic             clear_dirty;

	// Next-state values of one tick
	logic [3:0]  cw_use;
	logic [12:0] line_len_full;
	logic [11:0] line_len_new;
	logic [11:0] hsync_px_new;
	logic [8:0]  row_stride_new;
	logic [11:0] pixel_add;
	logic        line_wrap;
	logic [5:0]  scan_inc;
	logic        row_wrap;
	logic [8:0]  line_inc;
	logic [8:0]  char_row_inc;
	logic [17:0] row_prod;
	logic [15:0] row_addr;
	logic        frame_end;
	logic [4:0]  frame_cnt_inc;
	logic [11:0] pixel_n;
	logic [8:0]  line_n;
	logic [8:0]  char_row_n;
	logic [4:0]  scan_n;
	logic [15:0] mem_addr_n;
	logic        is_tick;
	logic        do_reload;

	// Advance the pipe whenever the result register is free or being drained.
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_fire   = in_valid && !in_stall;
	assign step_fire = valid_s1 && advance;
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign is_tick   = (op_s1 == ecrtc_pkg::OP_TICK);

	ecrtc_regfile #(
		.MAX_REG_INDEX(MAX_REG_INDEX)
	) u_regfile (
		.clk         (clk),
		.arst_n      (arst_n),
		.sel_en      (step_fire && (op_s1 == ecrtc_pkg::OP_SELECT)),
		.wr_en       (step_fire && (op_s1 == ecrtc_pkg::OP_WRITE)),
		.value       (value_s1),
		.clear_dirty (clear_dirty),
		.regs        (regs),
		.dirty       (dirty),
		.rdata       (rf_rdata)
	);

	// Derived timing from the current registers; a config write uses its new char width.
	always_comb begin
		cw_use         = cfg_fire ? char_width : cw_q;
		line_len_full  = 13'({1'b0, regs.htotal} + 9'd2) * 13'(cw_use);
		line_len_new   = line_len_full[11:0];
		hsync_px_new   = 12'(regs.hsync) * 12'(cw_use);
		row_stride_new = regs.byte_mode ? {1'b0, regs.offset} : {regs.offset, 1'b0};
	end

	// One character-clock tick: horizontal, then line, then frame.
	always_comb begin
		pixel_add     = pixel_q + 12'(cw_q);
		line_wrap     = (pixel_add >= line_len_q);
		scan_inc      = {1'b0, scan_q} + 6'd1;
		row_wrap      = (scan_inc > {1'b0, regs.max_scan});
		line_inc      = line_q + 9'd1;
		char_row_inc  = char_row_q + 9'd1;
		char_row_n    = char_row_q;
		scan_n        = scan_q;
		line_n        = line_q;
		pixel_n       = pixel_add;
		mem_addr_n    = mem_addr_q + 16'd1;
		if (line_wrap) begin
			pixel_n = '0;
			line_n  = line_inc;
			if (row_wrap) begin
				scan_n     = '0;
				char_row_n = char_row_inc;
			end else begin
				scan_n = scan_inc[4:0];
			end
		end
		row_prod = 18'(char_row_n) * 18'(row_stride_q);
		row_addr = regs.start_addr + row_prod[15:0];
		if (line_wrap) begin
			mem_addr_n = row_addr;
		end
		frame_end     = (line_n >= frame_lines_q);
		frame_cnt_inc = frame_cnt_q + 5'd1;
		if (frame_end) begin
			line_n     = '0;
			char_row_n = '0;
			scan_n     = '0;
			mem_addr_n = regs.start_addr;
		end
	end

	assign do_reload   = step_fire && is_tick && frame_end && dirty;
	assign clear_dirty = do_reload;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1    <= ecrtc_pkg::op_t'(operation);
			value_s1 <= value;
		end
	end

	// Char width and derived timing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q          <= ecrtc_pkg::CHAR_WIDTH_RST;
			line_len_q    <= '0;
			hsync_px_q    <= '0;
			frame_lines_q <= '0;
			vsync_line_q  <= '0;
			row_stride_q  <= '0;
		end else begin
			if (cfg_fire) begin
				cw_q <= char_width;
			end
			if (cfg_fire || do_reload) begin
				line_len_q    <= line_len_new;
				hsync_px_q    <= hsync_px_new;
				frame_lines_q <= regs.vtotal;
				vsync_line_q  <= regs.vsync;
				row_stride_q  <= row_stride_new;
			end
		end
	end

	// Counters and blink bits advance on ticks only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_q     <= '0;
			line_q      <= '0;
			char_row_q  <= '0;
			scan_q      <= '0;
			mem_addr_q  <= '0;
			frame_cnt_q <= '0;
			blink16_q   <= 1'b0;
			blink32_q   <= 1'b0;
		end else if (step_fire && is_tick) begin
			pixel_q    <= pixel_n;
			line_q     <= line_n;
			char_row_q <= char_row_n;
			scan_q     <= scan_n;
			mem_addr_q <= mem_addr_n;
			if (frame_end) begin
				frame_cnt_q <= frame_cnt_inc;
				// toggle every 16 frames, and every 32 when the count wraps to zero
				if (frame_cnt_inc[3:0] == 4'd0) begin
					blink16_q <= !blink16_q;
				end
				if (frame_cnt_inc == 5'd0) begin
					blink32_q <= !blink32_q;
				end
			end
		end
	end

	// Result register: hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			rd_q  <= (op_s1 == ecrtc_pkg::OP_READ) ? rf_rdata : 8'd0;
			eor_q <= is_tick && (pixel_add == hsync_px_q);
			nf_q  <= is_tick && (line_q == vsync_line_q);
			rf_q  <= is_tick && frame_end;
			mc_q  <= is_tick && frame_end && dirty;
		end
	end

	// Counter outputs show the state after the last completed word.
	assign out_valid      = out_valid_q;
	assign read_data      = rd_q;
	assign end_of_row     = eor_q;
	assign new_frame      = nf_q;
	assign render_frame   = rf_q;
	assign mode_changed   = mc_q;
	assign memory_address = mem_addr_q;
	assign scan_row       = scan_q;
	assign blink_fast     = blink16_q;
	assign blink_slow     = blink32_q;

endmodule

FILE: hdl/ecrtc_checker.sv
// Port-level assertions for the timing generator, bound to the top level.
`timescale 1ns / 1ps

module ecrtc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  read_data,
	input logic        end_of_row,
	input logic        new_frame,
	input logic        render_frame,
	input logic        mode_changed,
	input logic [15:0] memory_address,
	input logic [4:0]  scan_row
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data))
		else $error("result word dropped or changed while stalled");

	a_read_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_data != 8'd0) |->
			!end_of_row && !new_frame && !render_frame && !mode_changed)
		else $error("read word carries a tick event");

	a_reload_at_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_changed |-> render_frame)
		else $error("timing reload outside a frame end");

	a_frame_end_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && render_frame && !(out_stall && $past(out_valid)) |-> scan_row == 5'd0)
		else $error("scanline not cleared at frame end");

	a_stall_addr_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(memory_address))
		else $error("memory address moved while result stalled");

endmodule

bind ega_crtc_timing_generator ecrtc_checker u_ecrtc_checker (.*);
